// File: rtl/core/c2c_pkg.sv
package c2c_pkg;

  localparam int MAX_DIM_DEF    = 16;
  localparam int ENTRY_BITS_DEF = 32;

  localparam int IDX_W    = 4;
  localparam int VALUE_W  = 32;
  localparam int DIM_W    = 5;
  localparam int CORR_W   = 16;
  localparam int ERR_W    = 24;
  localparam int STATUS_W = 2;
  localparam int FRAC_SH  = 16;
  localparam int DIV_STEPS = 14;

  localparam logic [DIM_W-1:0]    DIM_RESET = DIM_W'(16);
  localparam logic [CORR_W-1:0]   ONE_Q14   = CORR_W'(16384);
  localparam logic [ERR_W-1:0]    ERR_MAX   = {ERR_W{1'b1}};

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_DIAG  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 2'd2;

  typedef enum logic [1:0] {
    CMD_LOAD,
    CMD_READ,
    CMD_BAD_READ
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t           kind;
    logic [IDX_W-1:0]    row;
    logic [IDX_W-1:0]    col;
    logic [VALUE_W-1:0]  value;
  } cmd_t;

endpackage

// File: rtl/core/c2c_front.sv
module c2c_front #(
  parameter int MAX_DIM = c2c_pkg::MAX_DIM_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  output logic                       full,
  input  logic                       req_type,
  input  logic [c2c_pkg::IDX_W-1:0]  row_index,
  input  logic [c2c_pkg::IDX_W-1:0]  col_index,
  input  logic [c2c_pkg::VALUE_W-1:0] entry_value,
  input  logic [c2c_pkg::DIM_W-1:0]  dimension,
  output logic                       cmd_valid,
  input  logic                       cmd_ready,
  output c2c_pkg::cmd_t              cmd
);
  import c2c_pkg::*;

  cmd_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       in_range;
  logic       accept;
  logic       enq;
  logic       deq;
  cmd_t       incoming;

  assign in_range = ({1'b0, row_index} < dimension) && ({1'b0, col_index} < dimension)
                  && (32'(row_index) < MAX_DIM) && (32'(col_index) < MAX_DIM);

  always_comb begin
    incoming.row   = row_index;
    incoming.col   = col_index;
    incoming.value = entry_value;
    if (!req_type) begin
      incoming.kind = CMD_LOAD;
    end else if (in_range) begin
      incoming.kind = CMD_READ;
    end else begin
      incoming.kind = CMD_BAD_READ;
    end
  end

  assign full      = (count == 2'd2);
  assign accept    = push && !full;
  // out-of-range loads are dropped here
  assign enq       = accept && (req_type || in_range);
  assign cmd_valid = (count != 2'd0);
  assign deq       = cmd_valid && cmd_ready;
  assign cmd       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (enq) begin
      slots[wr_ptr] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (enq) wr_ptr <= !wr_ptr;
      if (deq) rd_ptr <= !rd_ptr;
      unique case ({enq, deq})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: rtl/core/c2c_sqrt.sv
module c2c_sqrt #(
  parameter int SW = 24
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [2*SW-1:0] x,
  output logic            done,
  output logic [SW-1:0]   root
);

  localparam int CW = $clog2(SW + 1);

  logic [2*SW-1:0] xs;
  logic [SW+1:0]   rem;
  logic [CW-1:0]   cnt;
  logic            busy;
  logic [SW+1:0]   shifted;
  logic [SW+1:0]   trial;
  logic            take;

  // one result bit per cycle, two radicand bits consumed
  assign shifted = {rem[SW-1:0], xs[2*SW-1 -: 2]};
  assign trial   = {root, 2'b01};
  assign take    = (shifted >= trial);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(SW);
        xs   <= x;
        rem  <= '0;
        root <= '0;
      end else if (busy) begin
        xs   <= xs << 2;
        rem  <= take ? (shifted - trial) : shifted;
        root <= {root[SW-2:0], take};
        cnt  <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// File: rtl/core/c2c_back.sv
module c2c_back #(
  parameter int MAX_DIM    = c2c_pkg::MAX_DIM_DEF,
  parameter int ENTRY_BITS = c2c_pkg::ENTRY_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cmd_valid,
  output logic                         cmd_ready,
  input  c2c_pkg::cmd_t                cmd,
  output logic                         empty,
  input  logic                         pop,
  output logic [c2c_pkg::CORR_W-1:0]   correlation,
  output logic [c2c_pkg::ERR_W-1:0]    row_error,
  output logic [c2c_pkg::STATUS_W-1:0] status
);
  import c2c_pkg::*;

  localparam int EB    = ENTRY_BITS;
  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = $clog2(DEPTH);
  localparam int SW    = (ENTRY_BITS + FRAC_SH + 1) / 2;
  localparam int XW    = 2 * SW;
  localparam int DW    = 2 * SW + 1;
  localparam int EW    = SW + ERR_W;

  typedef enum logic [3:0] {
    S_IDLE, S_RDIAG, S_CDIAG, S_CROSS, S_LATCH, S_SQRT_R, S_SQRT_C,
    S_CHECK, S_MUL, S_DIVCHK, S_DIV, S_DONE
  } state_t;

  function automatic logic [AW-1:0] addr_of(logic [IDX_W-1:0] a, logic [IDX_W-1:0] b);
    addr_of = AW'(32'(a) * MAX_DIM + 32'(b));
  endfunction

  function automatic logic [XW-1:0] radicand(logic [EB-1:0] d);
    radicand = (!d[EB-1] && (d != '0)) ? XW'({d, 16'b0}) : '0;
  endfunction

  logic [EB-1:0]       mem [DEPTH];
  logic [EB-1:0]       rd_data;
  logic [AW-1:0]       mem_addr;

  state_t              state;
  logic [IDX_W-1:0]    r;
  logic [IDX_W-1:0]    c;
  logic [IDX_W-1:0]    hi;
  logic [IDX_W-1:0]    lo;
  logic [EB-1:0]       d_row;
  logic [EB-1:0]       d_col;
  logic [EB-1:0]       cross_val;
  logic [SW-1:0]       er;
  logic [SW-1:0]       ec;
  logic [DW-1:0]       num;
  logic [DW-1:0]       den;
  logic [DW-1:0]       num_sh;
  logic [CORR_W-1:0]   q;
  logic                negq;
  logic [3:0]          step;
  logic [STATUS_W-1:0] st;
  logic                out_full;
  logic [EB-1:0]       mag;
  logic [EW-1:0]       er_wide;

  logic                sqrt_start;
  logic [XW-1:0]       sqrt_x;
  logic                sqrt_done;
  logic [SW-1:0]       sqrt_root;

  assign hi        = (r > c) ? r : c;
  assign lo        = (r > c) ? c : r;
  assign cmd_ready = (state == S_IDLE);
  assign empty     = !out_full;
  assign mag       = cross_val[EB-1] ? (EB'(0) - cross_val) : cross_val;
  assign num_sh    = num << 1;
  assign er_wide   = EW'(er);

  always_comb begin
    unique case (state)
      S_CDIAG: mem_addr = addr_of(c, c);
      S_CROSS: mem_addr = addr_of(hi, lo);
      default: mem_addr = addr_of(r, r);
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd_valid && cmd_ready && (cmd.kind == CMD_LOAD)) begin
      mem[addr_of(cmd.row, cmd.col)] <= EB'($signed(cmd.value));
    end
    rd_data <= mem[mem_addr];
  end

  assign sqrt_start = (state == S_LATCH) || ((state == S_SQRT_R) && sqrt_done);
  assign sqrt_x     = (state == S_LATCH) ? radicand(d_row) : radicand(d_col);

  c2c_sqrt #(.SW(SW)) u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sqrt_start),
    .x     (sqrt_x),
    .done  (sqrt_done),
    .root  (sqrt_root)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      out_full <= 1'b0;
    end else begin
      if (out_full && pop) begin
        out_full <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            r <= cmd.row;
            c <= cmd.col;
            unique case (cmd.kind)
              CMD_READ: begin
                st    <= ST_OK;
                state <= S_RDIAG;
              end
              CMD_BAD_READ: begin
                st    <= ST_BAD_INDEX;
                q     <= '0;
                negq  <= 1'b0;
                er    <= '0;
                state <= S_DONE;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_RDIAG: state <= S_CDIAG;
        S_CDIAG: begin
          d_row <= rd_data;
          state <= S_CROSS;
        end
        S_CROSS: begin
          d_col <= rd_data;
          state <= S_LATCH;
        end
        S_LATCH: begin
          cross_val <= rd_data;
          state     <= S_SQRT_R;
        end
        S_SQRT_R: begin
          if (sqrt_done) begin
            er    <= sqrt_root;
            state <= S_SQRT_C;
          end
        end
        S_SQRT_C: begin
          if (sqrt_done) begin
            ec    <= sqrt_root;
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          negq <= 1'b0;
          q    <= '0;
          if ((er == '0) || (ec == '0)) begin
            st    <= ST_BAD_DIAG;
            state <= S_DONE;
          end else if (r == c) begin
            q     <= ONE_Q14;
            state <= S_DONE;
          end else begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          den   <= DW'(er) * DW'(ec);
          num   <= DW'({mag, 16'b0});
          negq  <= cross_val[EB-1];
          state <= S_DIVCHK;
        end
        S_DIVCHK: begin
          step <= '0;
          if (num >= den) begin
            q     <= ONE_Q14;
            state <= S_DONE;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          q   <= {q[CORR_W-2:0], (num_sh >= den)};
          num <= (num_sh >= den) ? (num_sh - den) : num_sh;
          step <= step + 4'd1;
          if (step == 4'(DIV_STEPS - 1)) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_full) begin
            out_full    <= 1'b1;
            correlation <= negq ? (CORR_W'(0) - q) : q;
            row_error   <= (er_wide > EW'(ERR_MAX)) ? ERR_MAX : er_wide[ERR_W-1:0];
            status      <= st;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/core/covariance_to_correlation.sv
// Load: one transaction per cycle while the back end is idle; stored once the back end takes it.
// Read: SW = (ENTRY_BITS+17)/2 is the root width of the shared bit-serial square root, which is
// run twice (row, then column diagonal), followed by a 14-step divider; diagonal or bad-diagonal
// reads skip the divider, and out-of-range reads skip the memory, square root and divider.
// Reads are processed one at a time; a 2-entry command queue decouples the input side.
// Synchronous active-high reset clears control state and sets dimension to 16.
module covariance_to_correlation #(
  parameter int MAX_DIM    = c2c_pkg::MAX_DIM_DEF,
  parameter int ENTRY_BITS = c2c_pkg::ENTRY_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic                          req_type,
  input  logic [c2c_pkg::IDX_W-1:0]     row_index,
  input  logic [c2c_pkg::IDX_W-1:0]     col_index,
  input  logic [c2c_pkg::VALUE_W-1:0]   entry_value,
  output logic                          empty,
  input  logic                          pop,
  output logic [c2c_pkg::CORR_W-1:0]    correlation,
  output logic [c2c_pkg::ERR_W-1:0]     row_error,
  output logic [c2c_pkg::STATUS_W-1:0]  status,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [c2c_pkg::DIM_W-1:0]     cfg_data
);
  import c2c_pkg::*;

  logic [DIM_W-1:0] dimension;
  logic             cmd_valid;
  logic             cmd_ready;
  cmd_t             cmd;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      dimension <= DIM_RESET;
    end else if (cfg_valid && cfg_ready) begin
      dimension <= cfg_data;
    end
  end

  c2c_front #(.MAX_DIM(MAX_DIM)) u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .req_type    (req_type),
    .row_index   (row_index),
    .col_index   (col_index),
    .entry_value (entry_value),
    .dimension   (dimension),
    .cmd_valid   (cmd_valid),
    .cmd_ready   (cmd_ready),
    .cmd         (cmd)
  );

  c2c_back #(.MAX_DIM(MAX_DIM), .ENTRY_BITS(ENTRY_BITS)) u_back (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (cmd_valid),
    .cmd_ready   (cmd_ready),
    .cmd         (cmd),
    .empty       (empty),
    .pop         (pop),
    .correlation (correlation),
    .row_error   (row_error),
    .status      (status)
  );

endmodule
